### rtl/pfbh_pkg.sv
// Shared types, constants and helpers for the font segment to ASCII hex converter.
`timescale 1ns / 1ps
`default_nettype none
package pfbh_pkg;

	localparam logic [7:0] SEG_MARK = 8'h80;
	localparam logic [7:0] SEG_END  = 8'h03;
	localparam logic [7:0] CHAR_NL  = 8'h0A;
	localparam logic [7:0] CHAR_0   = 8'h30;
	localparam logic [7:0] CHAR_A10 = 8'h37;   // 'A' - 10

	localparam logic [1:0] KIND_DISCARD = 2'd0;
	localparam logic [1:0] KIND_PASS    = 2'd1;
	localparam logic [1:0] KIND_HEX     = 2'd2;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		PH_FIRST   = 3'd0,
		PH_PASS    = 3'd1,
		PH_MARKER  = 3'd2,
		PH_TYPE    = 3'd3,
		PH_LENGTH  = 3'd4,
		PH_DATA    = 3'd5,
		PH_STOPPED = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		OP_NONE = 2'd0,
		OP_BYTE = 2'd1,
		OP_HEX  = 2'd2
	} op_t;

	// One classified request: what the back end must print for it.
	typedef struct packed {
		logic [7:0] data;
		op_t        op;
		logic       line_nl;   // newline after the two hex digits
		logic       final_nl;  // closing newline, flagged last
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_head_t;

	function automatic logic [7:0] hex_digit(input logic [3:0] v);
		logic [7:0] r;
		if (v <= 4'd9) begin
			r = CHAR_0 + {4'd0, v};
		end else begin
			r = CHAR_A10 + {4'd0, v};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### rtl/pfb_segment_to_ascii_hex_core.sv
// Top level: font segment deframer with ASCII hex expansion on stream ports.
// Path: an accepted request enters the command queue, then its characters the output register.
// Throughput: one input request per cycle into a 4-entry command queue while it has room; the
// output port emits one character per ready cycle; a hex byte gives 2 or 3 characters (4 with
// the closing newline), a pass-through byte 1. The character port sets the sustained rate.
// Reset: arst_n clears the deframer state, the queue and the output valid at once.
`timescale 1ns / 1ps
`default_nettype none
module pfb_segment_to_ascii_hex_core #(
	parameter int HEX_BYTES_PER_LINE = 32   // hex bytes per text line, 1..256
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// input request: one file byte
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,    // [7:0] in_byte
	input  wire logic       s_tlast,    // in_last
	// output request: one character
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,    // [7:0] out_byte
	output logic            m_tlast     // out_last
);
	import pfbh_pkg::*;

	logic    push;
	cmd_t    push_cmd;
	logic    q_ready;
	logic    pop;
	q_head_t head;

	// front: parses marker, type and length, tags each data byte
	pfbh_front #(
		.HEX_BYTES_PER_LINE(HEX_BYTES_PER_LINE)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_byte  (s_tdata),
		.in_last  (s_tlast),
		.q_ready  (q_ready),
		.in_ready (s_tready),
		.push     (push),
		.push_cmd (push_cmd)
	);

	// decouples parsing from character output; bytes with no output never enter
	pfbh_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.ready    (q_ready),
		.head     (head)
	);

	// back: hex digits, line newlines and the closing newline into a registered output
	pfbh_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (m_tdata),
		.out_last  (m_tlast)
	);

endmodule
`default_nettype wire

### rtl/pfbh_front.sv
// Front end: segment deframer that classifies each input byte into a print command.
`timescale 1ns / 1ps
`default_nettype none
module pfbh_front #(
	parameter int HEX_BYTES_PER_LINE = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic [7:0]    in_byte,
	input  wire logic          in_last,
	input  wire logic          q_ready,
	output logic               in_ready,
	output logic               push,
	output pfbh_pkg::cmd_t     push_cmd
);
	import pfbh_pkg::*;

	localparam logic [8:0] LINE_BYTES = 9'(HEX_BYTES_PER_LINE);

	phase_t      phase_q, phase_step, phase_d;
	logic [1:0]  kind_q, kind_d;
	logic [31:0] rem_q, rem_d, rem_asm;
	logic [1:0]  hcnt_q, hcnt_d;
	logic [7:0]  lpos_q, lpos_d;
	logic        line_end;
	logic        accept;
	cmd_t        cmd;

	assign in_ready = q_ready;
	assign accept   = in_valid & q_ready;
	assign line_end = ({1'b0, lpos_q} + 9'd1) >= LINE_BYTES;
	assign rem_asm  = {in_byte, rem_q[31:8]};   // little-endian length, low byte first

	// next state
	always_comb begin
		phase_step = phase_q;
		kind_d     = kind_q;
		rem_d      = rem_q;
		hcnt_d     = hcnt_q;
		lpos_d     = lpos_q;
		case (phase_q)
			PH_FIRST: begin
				phase_step = (in_byte == SEG_MARK) ? PH_TYPE : PH_PASS;
			end
			PH_PASS: begin
				phase_step = PH_PASS;
			end
			PH_MARKER: begin
				phase_step = (in_byte == SEG_MARK) ? PH_TYPE : PH_STOPPED;
			end
			PH_TYPE: begin
				if (in_byte == SEG_END) begin
					phase_step = PH_STOPPED;
				end else begin
					kind_d     = (in_byte == 8'(KIND_PASS) || in_byte == 8'(KIND_HEX))
					             ? in_byte[1:0] : KIND_DISCARD;
					rem_d      = '0;
					hcnt_d     = '0;
					phase_step = PH_LENGTH;
				end
			end
			PH_LENGTH: begin
				rem_d = rem_asm;
				if (hcnt_q == 2'd3) begin
					hcnt_d     = '0;
					lpos_d     = '0;
					phase_step = (rem_asm == '0) ? PH_MARKER : PH_DATA;
				end else begin
					hcnt_d = hcnt_q + 2'd1;
				end
			end
			PH_DATA: begin
				if (kind_q == KIND_HEX) begin
					lpos_d = line_end ? 8'd0 : lpos_q + 8'd1;
				end
				rem_d = rem_q - 32'd1;
				if (rem_q == 32'd1) begin
					phase_step = PH_MARKER;
				end
			end
			default: begin
				phase_step = phase_q;
			end
		endcase
		phase_d = phase_step;
		// end of file re-arms everything as after reset
		if (in_last) begin
			phase_d = PH_FIRST;
			kind_d  = '0;
			rem_d   = '0;
			hcnt_d  = '0;
			lpos_d  = '0;
		end
	end

	// outputs
	always_comb begin
		cmd.data     = in_byte;
		cmd.op       = OP_NONE;
		cmd.line_nl  = 1'b0;
		cmd.final_nl = 1'b0;
		case (phase_q)
			PH_FIRST: begin
				if (in_byte != SEG_MARK) cmd.op = OP_BYTE;
			end
			PH_PASS: begin
				cmd.op = OP_BYTE;
			end
			PH_MARKER: begin
				if (in_byte != SEG_MARK) cmd.final_nl = 1'b1;
			end
			PH_TYPE: begin
				if (in_byte == SEG_END) cmd.final_nl = 1'b1;
			end
			PH_DATA: begin
				if (kind_q == KIND_PASS) begin
					cmd.op = OP_BYTE;
				end else if (kind_q == KIND_HEX) begin
					cmd.op      = OP_HEX;
					cmd.line_nl = line_end;
				end
			end
			default: begin
				cmd.op = OP_NONE;
			end
		endcase
		if (in_last && phase_step != PH_STOPPED) cmd.final_nl = 1'b1;
	end

	assign push_cmd = cmd;
	assign push     = accept & ((cmd.op != OP_NONE) | cmd.final_nl);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			kind_q  <= '0;
			rem_q   <= '0;
			hcnt_q  <= '0;
			lpos_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			kind_q  <= kind_d;
			rem_q   <= rem_d;
			hcnt_q  <= hcnt_d;
			lpos_q  <= lpos_d;
		end
	end

endmodule
`default_nettype wire

### rtl/pfbh_queue.sv
// Short command queue between the deframer and the character emitter.
`timescale 1ns / 1ps
`default_nettype none
module pfbh_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire pfbh_pkg::cmd_t push_cmd,
	input  wire logic           pop,
	output logic                ready,
	output pfbh_pkg::q_head_t   head
);
	import pfbh_pkg::*;

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q, rptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign ready      = cnt_q != QCNT_W'(QUEUE_DEPTH);
	assign head.valid = cnt_q != '0;
	assign head.cmd   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + QPTR_W'(1);
			if (pop)  rptr_q <= rptr_q + QPTR_W'(1);
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

### rtl/pfbh_back.sv
// Back end: expands queued commands into characters, one per ready cycle.
`timescale 1ns / 1ps
`default_nettype none
module pfbh_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pfbh_pkg::q_head_t head,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [7:0]             out_byte,
	output logic                   out_last
);
	import pfbh_pkg::*;

	logic [7:0] seq [4];
	logic [2:0] n_chars;
	logic [1:0] idx_q;
	logic       is_last_char;
	logic       load;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;

	// character sequence of the head command
	always_comb begin
		seq[0]  = CHAR_NL;
		seq[1]  = CHAR_NL;
		seq[2]  = CHAR_NL;
		seq[3]  = CHAR_NL;
		n_chars = 3'd0;
		case (head.cmd.op)
			OP_BYTE: begin
				seq[0]  = head.cmd.data;
				n_chars = 3'd1;
			end
			OP_HEX: begin
				seq[0]  = hex_digit(head.cmd.data[7:4]);
				seq[1]  = hex_digit(head.cmd.data[3:0]);
				n_chars = head.cmd.line_nl ? 3'd3 : 3'd2;
			end
			default: begin
				n_chars = 3'd0;
			end
		endcase
		// closing newline is CHAR_NL already in the slot after the body
		if (head.cmd.final_nl) n_chars = n_chars + 3'd1;
	end

	assign is_last_char = {1'b0, idx_q} == (n_chars - 3'd1);
	assign load         = head.valid & (~valid_q | out_ready);
	assign pop          = load & is_last_char;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= is_last_char ? 2'd0 : idx_q + 2'd1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= seq[idx_q];
			last_q <= head.cmd.final_nl & is_last_char;
		end
	end

	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign out_last  = last_q;

	a_head_held: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != 2'd0 |-> head.valid)
		else $error("command left the queue mid-expansion");
	a_pop_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> load && head.valid)
		else $error("pop without a character issued");
	a_last_is_nl: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && last_q |-> byte_q == CHAR_NL)
		else $error("final character is not a newline");

endmodule
`default_nettype wire

### dv/pfb_segment_to_ascii_hex_core_tb.sv
// Testbench for the font segment deframer: directed table plus random files, scoreboarded.
`timescale 1ns / 1ps
module pfb_segment_to_ascii_hex_core_tb;
	import pfbh_pkg::*;

	localparam int LINE_BYTES  = 32;     // hex bytes per text line
	localparam int HOLD_CYCLES = 160;    // long receiver hold-off
	localparam int RAND_ITEMS  = 194;    // with the directed rows, about 220 requests
	localparam int DRAIN_WAIT  = 20;     // idle cycles after the last character
	localparam logic [8:0] NO  = 9'h000; // unused slot in a typed row
	localparam logic [8:0] FIN = {1'b1, CHAR_NL};

	// one file byte with its end flag
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} file_byte_t;

	// directed row: n_chars < 0 means the row is checked against the predictor
	typedef struct {
		logic [7:0]       data;
		logic             last;
		int               n_chars;
		logic [0:3][8:0]  chars;   // {last, byte}, first character in slot 0
	} dir_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic       s_tlast = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic       m_tlast;

	// idling knobs, set at a rising edge; the receiver clears long_hold after its hold-off
	int   tx_idle_pct = 0;
	int   rx_stall_pct = 0;
	logic long_hold = 1'b0;

	// predictor state
	phase_t      dfr_phase = PH_FIRST;
	logic [1:0]  seg_kind = KIND_DISCARD;
	logic [31:0] seg_left = '0;
	logic [1:0]  len_idx = '0;
	logic [7:0]  hex_col = '0;

	logic [8:0]  char_q[$];     // expected characters, {last, byte}
	file_byte_t  file_q[$];     // bytes of the file being built
	dir_row_t    dir_tab[26];

	int fail_cnt = 0;
	int bytes_sent = 0;
	int files_sent = 0;
	int chars_checked = 0;
	int in_stalls = 0;
	int rand_sent = 0;

	always #6 clk = ~clk;

	pfb_segment_to_ascii_hex_core #(
		.HEX_BYTES_PER_LINE(LINE_BYTES)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	function automatic logic [8:0] ch(input logic [7:0] b);
		return {1'b0, b};
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		return (v < 4'd10) ? (8'h30 + v) : (8'h41 - 8'd10 + v);
	endfunction

	// Predicts the characters one accepted file byte produces (0 to 4).
	task automatic deframe_step(input logic [7:0] b, input logic l,
			output logic [0:3][8:0] res, output int n);
		n = 0;
		res = '0;
		case (dfr_phase)
			PH_FIRST: begin
				if (b == SEG_MARK) begin
					dfr_phase = PH_TYPE;
				end else begin
					res[n] = ch(b);
					n++;
					dfr_phase = PH_PASS;
				end
			end
			PH_PASS: begin
				res[n] = ch(b);
				n++;
			end
			PH_MARKER: begin
				if (b == SEG_MARK) begin
					dfr_phase = PH_TYPE;
				end else begin
					// anything but a marker ends the stream
					res[n] = FIN;
					n++;
					dfr_phase = PH_STOPPED;
				end
			end
			PH_TYPE: begin
				if (b == SEG_END) begin
					res[n] = FIN;
					n++;
					dfr_phase = PH_STOPPED;
				end else begin
					if (b == 8'd1)
						seg_kind = KIND_PASS;
					else if (b == 8'd2)
						seg_kind = KIND_HEX;
					else
						seg_kind = KIND_DISCARD;
					seg_left = '0;
					len_idx = '0;
					dfr_phase = PH_LENGTH;
				end
			end
			PH_LENGTH: begin
				// little-endian length, low byte first
				seg_left[8 * len_idx +: 8] = b;
				if (len_idx == 2'd3) begin
					len_idx = '0;
					hex_col = '0;
					dfr_phase = (seg_left == 0) ? PH_MARKER : PH_DATA;
				end else begin
					len_idx = len_idx + 2'd1;
				end
			end
			PH_DATA: begin
				if (seg_kind == KIND_PASS) begin
					res[n] = ch(b);
					n++;
				end else if (seg_kind == KIND_HEX) begin
					res[n] = ch(hex_char(b[7:4]));
					n++;
					res[n] = ch(hex_char(b[3:0]));
					n++;
					if (int'(hex_col) + 1 >= LINE_BYTES) begin
						res[n] = ch(CHAR_NL);
						n++;
						hex_col = '0;
					end else begin
						hex_col = hex_col + 8'd1;
					end
				end
				seg_left = seg_left - 32'd1;
				if (seg_left == 0)
					dfr_phase = PH_MARKER;
			end
			default: ;
		endcase
		if (l) begin
			if (dfr_phase != PH_STOPPED) begin
				res[n] = FIN;
				n++;
			end
			// file done: back to waiting for a new first byte
			dfr_phase = PH_FIRST;
			seg_kind = KIND_DISCARD;
			seg_left = '0;
			len_idx = '0;
			hex_col = '0;
		end
	endtask

	// Offers one request from a falling edge; returns at the falling edge after it
	// is taken, with tvalid still high so back-to-back requests need no toggle.
	task automatic send_req(input logic [7:0] b, input logic l, input int n_chars,
			input logic [0:3][8:0] chars);
		logic [0:3][8:0] pred;
		int              npred;
		while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = b;
		s_tlast = l;
		do
			@(posedge clk);
		while (!s_tready);
		deframe_step(b, l, pred, npred);
		if (n_chars < 0) begin
			for (int k = 0; k < npred; k++)
				char_q.push_back(pred[k]);
		end else begin
			for (int k = 0; k < n_chars; k++)
				char_q.push_back(chars[k]);
		end
		bytes_sent++;
		if (l)
			files_sent++;
		@(negedge clk);
	endtask

	// Sender goes quiet until every expected character is out.
	task automatic drain;
		s_tvalid = 1'b0;
		while (char_q.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_idling(input int tx, input int rx, input logic hold);
		@(posedge clk);
		tx_idle_pct = tx;
		rx_stall_pct = rx;
		long_hold = hold;
		@(negedge clk);
	endtask

	task automatic put(input logic [7:0] b, input logic l);
		file_q.push_back('{data: b, last: l});
	endtask

	// Builds one random file into file_q: mostly well-formed segment files,
	// plus plain files, broken markers and truncated ones.
	task automatic build_file;
		int          pick;
		int          nseg;
		int          cut;
		logic [7:0]  t;
		logic [7:0]  b;
		logic [31:0] len;
		file_q.delete();
		pick = $urandom_range(99);
		if (pick < 12) begin
			// plain file, no segment marker up front
			b = 8'($urandom_range(255));
			if (b == SEG_MARK)
				b = 8'h7F;
			put(b, 1'b0);
			repeat ($urandom_range(1, 12))
				put(8'($urandom_range(255)), 1'b0);
			file_q[file_q.size() - 1].last = 1'b1;
		end else if (pick < 85) begin
			nseg = $urandom_range(1, 3);
			for (int s = 0; s < nseg; s++) begin
				put(SEG_MARK, 1'b0);
				pick = $urandom_range(99);
				if (pick < 45)
					t = 8'd2;
				else if (pick < 80)
					t = 8'd1;
				else if (pick < 90)
					t = 8'd0;
				else
					t = 8'($urandom_range(4, 255));
				put(t, 1'b0);
				pick = $urandom_range(99);
				if (pick < 10)
					len = 0;
				else if (pick < 78)
					len = $urandom_range(1, 12);
				else
					len = $urandom_range(30, 70);  // crosses hex line breaks
				for (int k = 0; k < 4; k++)
					put(len[8 * k +: 8], 1'b0);
				for (int d = 0; d < int'(len); d++)
					put(8'($urandom_range(255)), 1'b0);
			end
			pick = $urandom_range(2);
			if (pick == 0) begin
				// explicit end segment, maybe followed by an ignored closing byte
				put(SEG_MARK, 1'b0);
				if ($urandom_range(1)) begin
					put(SEG_END, 1'b1);
				end else begin
					put(SEG_END, 1'b0);
					put(8'($urandom_range(255)), 1'b1);
				end
			end else if (pick == 1) begin
				file_q[file_q.size() - 1].last = 1'b1;
			end else begin
				b = 8'($urandom_range(255));
				if (b == SEG_MARK)
					b = 8'h00;
				if ($urandom_range(1)) begin
					put(b, 1'b1);
				end else begin
					put(b, 1'b0);
					put(8'($urandom_range(255)), 1'b1);
				end
			end
		end else begin
			// truncated: huge length, file ends in the header or early in the data
			put(SEG_MARK, 1'b0);
			put(8'($urandom_range(1, 2)), 1'b0);
			len = {8'($urandom_range(1, 255)), 24'($urandom)};
			for (int k = 0; k < 4; k++)
				put(len[8 * k +: 8], 1'b0);
			repeat ($urandom_range(0, 5))
				put(8'($urandom_range(255)), 1'b0);
			cut = $urandom_range(2, file_q.size());
			while (file_q.size() > cut)
				void'(file_q.pop_back());
			file_q[file_q.size() - 1].last = 1'b1;
		end
	endtask

	// Receiver: random stalls per cycle, and a long hold-off when asked.
	always begin
		@(negedge clk);
		if (long_hold) begin
			m_tready = 1'b0;
			repeat (HOLD_CYCLES)
				@(negedge clk);
			long_hold = 1'b0;
		end
		m_tready = (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
	end

	// Output scoreboard: each character against the oldest expectation.
	always @(posedge clk) begin
		logic [8:0] exp_c;
		if (arst_n) begin
			if (s_tvalid && !s_tready)
				in_stalls++;
			if (m_tvalid && m_tready) begin
				chars_checked++;
				if (char_q.size() == 0) begin
					$error("unexpected character: out_byte=%02h out_last=%0d",
						m_tdata, m_tlast);
					fail_cnt++;
				end else begin
					exp_c = char_q.pop_front();
					if (m_tdata !== exp_c[7:0]) begin
						$error("out_byte: expected %02h, got %02h", exp_c[7:0], m_tdata);
						fail_cnt++;
					end
					if (m_tlast !== exp_c[8]) begin
						$error("out_last: expected %0d, got %0d", exp_c[8], m_tlast);
						fail_cnt++;
					end
				end
			end
		end
	end

	// Watchdog.
	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int target;
		dir_tab = '{
			// plain file: bytes copied, closing newline flagged last
			'{8'hFF, 1'b0, 1, {ch(8'hFF), NO, NO, NO}},
			'{8'h00, 1'b1, 2, {ch(8'h00), FIN, NO, NO}},
			// segment file: hex segment of one byte
			'{SEG_MARK, 1'b0, 0, '0},
			'{8'h02, 1'b0, -1, '0},
			'{8'h01, 1'b0, -1, '0},
			'{8'h00, 1'b0, -1, '0},
			'{8'h00, 1'b0, -1, '0},
			'{8'h00, 1'b0, -1, '0},
			'{8'hA5, 1'b0, 2, {ch("A"), ch("5"), NO, NO}},
			// unknown type with zero length: next byte must be a marker
			'{SEG_MARK, 1'b0, -1, '0},
			'{8'h07, 1'b0, -1, '0},
			'{8'h00, 1'b0, -1, '0},
			'{8'h00, 1'b0, -1, '0},
			'{8'h00, 1'b0, -1, '0},
			'{8'h00, 1'b0, -1, '0},
			// bad marker stops the stream; later bytes are ignored
			'{8'h41, 1'b0, 1, {FIN, NO, NO, NO}},
			'{8'h12, 1'b1, 0, '0},
			// end type on the last byte: only one closing newline
			'{SEG_MARK, 1'b0, -1, '0},
			'{SEG_END, 1'b1, 1, {FIN, NO, NO, NO}},
			// pass segment whose data ends the file
			'{SEG_MARK, 1'b0, -1, '0},
			'{8'h01, 1'b0, -1, '0},
			'{8'h01, 1'b0, -1, '0},
			'{8'h00, 1'b0, -1, '0},
			'{8'h00, 1'b0, -1, '0},
			'{8'h00, 1'b0, -1, '0},
			'{8'hFF, 1'b1, 2, {ch(8'hFF), FIN, NO, NO}}
		};

		repeat (9)
			@(negedge clk);
		arst_n = 1'b1;
		set_idling(0, 0, 1'b0);

		foreach (dir_tab[i])
			send_req(dir_tab[i].data, dir_tab[i].last, dir_tab[i].n_chars,
				dir_tab[i].chars);
		drain();

		// random files, one idling pattern per phase, drained in between
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: set_idling(47, 0, 1'b0);
				1: set_idling(0, 47, 1'b0);
				2: set_idling(31, 31, 1'b0);
				default: set_idling(0, 0, 1'b1);  // full-rate sender into a held receiver
			endcase
			target = RAND_ITEMS * (p + 1) / 4;
			while (rand_sent < target) begin
				build_file();
				foreach (file_q[i]) begin
					// phase budget used up: the file ends here
					if (rand_sent + 1 >= target)
						file_q[i].last = 1'b1;
					send_req(file_q[i].data, file_q[i].last, -1, '0);
					rand_sent++;
					if (file_q[i].last)
						break;
				end
			end
			drain();
		end

		repeat (DRAIN_WAIT)
			@(posedge clk);

		$display("Sent %0d file bytes in %0d files; checked %0d characters.",
			bytes_sent, files_sent, chars_checked);
		$display("Input back-pressure seen on %0d cycles; %0d mismatches.",
			in_stalls, fail_cnt);
		if (fail_cnt == 0 && char_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
